// File: design/postfix_prefix_evaluator_unit_macros.svh
// ----------------------------------------------------------------------------
// Postfix / prefix evaluator assertion macros
// Concurrent assertion helpers, active only outside synthesis.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_PREFIX_EVALUATOR_UNIT_MACROS_SVH
`define POSTFIX_PREFIX_EVALUATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define PPE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define PPE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PPE_ASSERT_SAME(label, ante, cons, msg)
`define PPE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: design/ppe_pkg.sv
// ----------------------------------------------------------------------------
// Postfix / prefix evaluator package
// Shared constants, payload types and controller interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppe_pkg;

   localparam int StackDepth = 32;
   localparam int DataW      = 32;
   localparam int AddrW      = $clog2(StackDepth);
   localparam int CountW     = $clog2(StackDepth + 1);
   localparam int SymW       = 8;
   localparam int DivCntW    = $clog2(DataW);

   localparam logic [SymW-1:0] SymZero    = 8'h30;
   localparam logic [SymW-1:0] SymNine    = 8'h39;
   localparam logic [SymW-1:0] SymPlus    = 8'h2B;
   localparam logic [SymW-1:0] SymMinus   = 8'h2D;
   localparam logic [SymW-1:0] SymStar    = 8'h2A;
   localparam logic [SymW-1:0] SymSlash   = 8'h2F;
   localparam logic [SymW-1:0] SymPercent = 8'h25;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_MOD
   } ppe_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD1,
      ST_RD2,
      ST_OPER,
      ST_DIV,
      ST_PUSH,
      ST_TOP,
      ST_EMIT
   } ppe_state_type;

   typedef struct packed {
      logic [SymW-1:0] symbol;
      logic            last;
   } ppe_req_type;

   typedef struct packed {
      logic signed [DataW-1:0] value;
      logic                    empty_at_end;
      logic                    underflow_seen;
      logic                    overflow_seen;
      logic                    div_zero_seen;
   } ppe_rsp_type;

   typedef struct packed {
      logic accept;
      logic pop1;
      logic pop2;
      logic oper;
      logic div_finish;
      logic push;
      logic top;
      logic emit;
   } ppe_cmd_type;

   typedef struct packed {
      logic req_digit;
      logic is_arith;
      logic is_divop;
      logic div_zero;
      logic div_done;
      logic last;
      logic out_free;
   } ppe_status_type;

endpackage

// File: design/ppe_divider.sv
// ----------------------------------------------------------------------------
// Postfix / prefix evaluator divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppe_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ppe_pkg::DataW-1:0]    dividend,
   input  logic [ppe_pkg::DataW-1:0]    divisor,
   output logic [ppe_pkg::DataW-1:0]    quotient,
   output logic [ppe_pkg::DataW-1:0]    remainder,
   output logic                         done
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [ppe_pkg::DivCntW-1:0]   cnt_ff, cnt_in;
   logic [ppe_pkg::DataW-1:0]     quo_ff, quo_in;
   logic [ppe_pkg::DataW-1:0]     rem_ff, rem_in;
   logic [ppe_pkg::DataW-1:0]     den_ff, den_in;
   logic [ppe_pkg::DataW:0]       shifted;
   logic [ppe_pkg::DataW:0]       diff;

   assign shifted = {rem_ff, quo_ff[ppe_pkg::DataW-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // A non-negative trial difference means this quotient bit is one.
         if (!diff[ppe_pkg::DataW]) begin
            rem_in = diff[ppe_pkg::DataW-1:0];
            quo_in = {quo_ff[ppe_pkg::DataW-2:0], 1'b1};
         end else begin
            rem_in = shifted[ppe_pkg::DataW-1:0];
            quo_in = {quo_ff[ppe_pkg::DataW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ppe_pkg::DivCntW'(ppe_pkg::DataW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// File: design/ppe_datapath.sv
// ----------------------------------------------------------------------------
// Postfix / prefix evaluator datapath
// Stack memory, operand registers, arithmetic, flags and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppe_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_wdata,
   input  ppe_pkg::ppe_req_type    req_payload,
   input  ppe_pkg::ppe_cmd_type    cmd,
   output ppe_pkg::ppe_status_type status,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output ppe_pkg::ppe_rsp_type    rsp_payload
);

   logic [ppe_pkg::DataW-1:0]  stack_mem [ppe_pkg::StackDepth];
   logic                       rd_en;
   logic [ppe_pkg::AddrW-1:0]  rd_addr;
   logic [ppe_pkg::DataW-1:0]  rd_data_ff;
   logic                       wr_en;

   logic                       notation_ff;
   logic [ppe_pkg::CountW-1:0] count_ff, count_in;
   logic                       under_ff, under_in;
   logic                       over_ff, over_in;
   logic                       divz_ff, divz_in;
   logic [ppe_pkg::SymW-1:0]   symbol_ff, symbol_in;
   logic                       last_ff, last_in;
   logic                       first_mem_ff, first_mem_in;
   logic                       second_mem_ff, second_mem_in;
   logic [ppe_pkg::DataW-1:0]  op1_ff, op1_in;
   logic [ppe_pkg::DataW-1:0]  res_ff, res_in;
   logic                       lhs_neg_ff, lhs_neg_in;
   logic                       rhs_neg_ff, rhs_neg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   ppe_pkg::ppe_rsp_type       rsp_ff, rsp_in;

   ppe_pkg::ppe_op_type        op;
   logic [ppe_pkg::DataW-1:0]  second_val;
   logic [ppe_pkg::DataW-1:0]  lhs, rhs;
   logic [ppe_pkg::DataW-1:0]  lhs_mag, rhs_mag;
   logic [ppe_pkg::DataW-1:0]  prod_lo;
   logic                       rhs_zero;
   logic                       div_start;
   logic [ppe_pkg::DataW-1:0]  div_quo, div_rem;
   logic                       div_done;
   logic                       out_free;
   logic [ppe_pkg::SymW-1:0]   digit_val;

   always_comb begin
      unique case (symbol_ff)
         ppe_pkg::SymPlus:    op = ppe_pkg::OP_ADD;
         ppe_pkg::SymMinus:   op = ppe_pkg::OP_SUB;
         ppe_pkg::SymStar:    op = ppe_pkg::OP_MUL;
         ppe_pkg::SymSlash:   op = ppe_pkg::OP_DIV;
         ppe_pkg::SymPercent: op = ppe_pkg::OP_MOD;
         default:             op = ppe_pkg::OP_NONE;
      endcase
   end

   // A pop that found the stack empty contributes all ones.
   assign second_val = second_mem_ff ? rd_data_ff : '1;
   assign lhs        = notation_ff ? op1_ff : second_val;
   assign rhs        = notation_ff ? second_val : op1_ff;
   assign lhs_mag    = lhs[ppe_pkg::DataW-1] ? (~lhs + 1'b1) : lhs;
   assign rhs_mag    = rhs[ppe_pkg::DataW-1] ? (~rhs + 1'b1) : rhs;
   assign prod_lo    = lhs * rhs;
   assign rhs_zero   = (rhs == '0);
   assign div_start  = cmd.oper && !rhs_zero &&
                       (op == ppe_pkg::OP_DIV || op == ppe_pkg::OP_MOD);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign digit_val  = req_payload.symbol - ppe_pkg::SymZero;

   ppe_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (lhs_mag),
      .divisor   (rhs_mag),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   always_comb begin
      count_in      = count_ff;
      under_in      = under_ff;
      over_in       = over_ff;
      divz_in       = divz_ff;
      symbol_in     = symbol_ff;
      last_in       = last_ff;
      first_mem_in  = first_mem_ff;
      second_mem_in = second_mem_ff;
      op1_in        = op1_ff;
      res_in        = res_ff;
      lhs_neg_in    = lhs_neg_ff;
      rhs_neg_in    = rhs_neg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = ppe_pkg::AddrW'(count_ff - 1'b1);
      wr_en         = 1'b0;

      if (cmd.accept) begin
         symbol_in = req_payload.symbol;
         last_in   = req_payload.last;
         res_in    = {{(ppe_pkg::DataW - ppe_pkg::SymW){1'b0}}, digit_val};
      end

      if (cmd.pop1) begin
         if (count_ff == '0) begin
            under_in     = 1'b1;
            first_mem_in = 1'b0;
         end else begin
            rd_en        = 1'b1;
            first_mem_in = 1'b1;
            count_in     = count_ff - 1'b1;
         end
      end

      if (cmd.pop2) begin
         op1_in = first_mem_ff ? rd_data_ff : '1;
         if (count_ff == '0) begin
            under_in      = 1'b1;
            second_mem_in = 1'b0;
         end else begin
            rd_en         = 1'b1;
            second_mem_in = 1'b1;
            count_in      = count_ff - 1'b1;
         end
      end

      if (cmd.oper) begin
         lhs_neg_in = lhs[ppe_pkg::DataW-1];
         rhs_neg_in = rhs[ppe_pkg::DataW-1];
         case (op)
            ppe_pkg::OP_ADD: res_in = lhs + rhs;
            ppe_pkg::OP_SUB: res_in = lhs - rhs;
            ppe_pkg::OP_MUL: res_in = prod_lo;
            default: begin
               res_in = '0;
               if (rhs_zero && op != ppe_pkg::OP_NONE) begin
                  divz_in = 1'b1;
               end
            end
         endcase
      end

      if (cmd.div_finish) begin
         if (op == ppe_pkg::OP_MOD) begin
            res_in = lhs_neg_ff ? (~div_rem + 1'b1) : div_rem;
         end else begin
            res_in = (lhs_neg_ff ^ rhs_neg_ff) ? (~div_quo + 1'b1) : div_quo;
         end
      end

      if (cmd.push) begin
         if (count_ff == ppe_pkg::CountW'(ppe_pkg::StackDepth)) begin
            over_in = 1'b1;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end

      if (cmd.top) begin
         rd_en = (count_ff != '0);
      end

      if (cmd.emit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.value          = (count_ff == '0) ? '0 : rd_data_ff;
         rsp_in.empty_at_end   = (count_ff == '0);
         rsp_in.underflow_seen = under_ff;
         rsp_in.overflow_seen  = over_ff;
         rsp_in.div_zero_seen  = divz_ff;
         count_in              = '0;
         under_in              = 1'b0;
         over_in               = 1'b0;
         divz_in               = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[count_ff[ppe_pkg::AddrW-1:0]] <= res_ff;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         notation_ff  <= 1'b0;
         count_ff     <= '0;
         under_ff     <= 1'b0;
         over_ff      <= 1'b0;
         divz_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            notation_ff <= csr_wdata;
         end
         count_ff     <= count_in;
         under_ff     <= under_in;
         over_ff      <= over_in;
         divz_ff      <= divz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff     <= symbol_in;
      last_ff       <= last_in;
      first_mem_ff  <= first_mem_in;
      second_mem_ff <= second_mem_in;
      op1_ff        <= op1_in;
      res_ff        <= res_in;
      lhs_neg_ff    <= lhs_neg_in;
      rhs_neg_ff    <= rhs_neg_in;
      rsp_ff        <= rsp_in;
   end

   assign status.req_digit = (req_payload.symbol >= ppe_pkg::SymZero) &&
                             (req_payload.symbol <= ppe_pkg::SymNine);
   assign status.is_arith  = (op == ppe_pkg::OP_ADD) || (op == ppe_pkg::OP_SUB) ||
                             (op == ppe_pkg::OP_MUL);
   assign status.is_divop  = (op == ppe_pkg::OP_DIV) || (op == ppe_pkg::OP_MOD);
   assign status.div_zero  = rhs_zero;
   assign status.div_done  = div_done;
   assign status.last      = last_ff;
   assign status.out_free  = out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: design/ppe_controller.sv
// ----------------------------------------------------------------------------
// Postfix / prefix evaluator controller
// Sequences pops, the operation, the push and the end-of-expression beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppe_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ppe_pkg::ppe_status_type status,
   output ppe_pkg::ppe_cmd_type    cmd,
   output ppe_pkg::ppe_state_type  fsm_state
);

   ppe_pkg::ppe_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppe_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.req_digit ? ppe_pkg::ST_PUSH : ppe_pkg::ST_RD1;
            end
         end
         ppe_pkg::ST_RD1: state_in = ppe_pkg::ST_RD2;
         ppe_pkg::ST_RD2: state_in = ppe_pkg::ST_OPER;
         ppe_pkg::ST_OPER: begin
            if (status.is_arith || (status.is_divop && status.div_zero)) begin
               state_in = ppe_pkg::ST_PUSH;
            end else if (status.is_divop) begin
               state_in = ppe_pkg::ST_DIV;
            end else begin
               state_in = status.last ? ppe_pkg::ST_TOP : ppe_pkg::ST_IDLE;
            end
         end
         ppe_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = ppe_pkg::ST_PUSH;
            end
         end
         ppe_pkg::ST_PUSH: state_in = status.last ? ppe_pkg::ST_TOP : ppe_pkg::ST_IDLE;
         ppe_pkg::ST_TOP:  state_in = ppe_pkg::ST_EMIT;
         ppe_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = ppe_pkg::ST_IDLE;
            end
         end
         default: state_in = ppe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ppe_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ppe_pkg::ST_RD1:  cmd.pop1 = 1'b1;
         ppe_pkg::ST_RD2:  cmd.pop2 = 1'b1;
         ppe_pkg::ST_OPER: cmd.oper = 1'b1;
         ppe_pkg::ST_DIV:  cmd.div_finish = status.div_done;
         ppe_pkg::ST_PUSH: cmd.push = 1'b1;
         ppe_pkg::ST_TOP:  cmd.top = 1'b1;
         ppe_pkg::ST_EMIT: cmd.emit = status.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign fsm_state = state_ff;

endmodule

// File: design/postfix_prefix_evaluator_unit.sv
// Each beat walks the controller states: a digit goes through push; any other character
// goes through the two pops and the operate step; + - * or a zero
// divisor add a push; / and % also wait in the divide state for the bit-serial divider. A last
// beat then reads the stack top and may stall while the previous result still waits in the
// output register. One beat is in flight at a time. Synchronous active-high reset clears the
// stack count, the flags, notation and the controller; stack memory is not cleared.
// ----------------------------------------------------------------------------
// Postfix / prefix evaluator
// Stack-based integer expression evaluator fed one character per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "postfix_prefix_evaluator_unit_macros.svh"

module postfix_prefix_evaluator_unit (
   input  logic                 clock,
   input  logic                 reset,
   // Configuration: bit 0 selects prefix notation when set.
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   // Character beats in.
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ppe_pkg::ppe_req_type req_payload,
   // One result beat per expression out.
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ppe_pkg::ppe_rsp_type rsp_payload
);

   // The controller and datapath talk only through these two structs. The
   // controller walks each character through pop, operate and push steps,
   // while the datapath owns the stack memory, the flags and the divider.
   ppe_pkg::ppe_cmd_type    cmd;
   ppe_pkg::ppe_status_type status;
   ppe_pkg::ppe_state_type  fsm_state;

   ppe_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .fsm_state (fsm_state)
   );

   // The result sits in an output register, so the next expression can
   // start while the previous result waits for the consumer.
   ppe_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // A new result only ever comes from the emit step.
   `PPE_ASSERT_SAME(a_rsp_from_emit, $rose(rsp_valid),
                    $past(fsm_state) == ppe_pkg::ST_EMIT, "result raised outside emit")
   // Every accepted beat takes the controller out of the idle state.
   `PPE_ASSERT_NEXT(a_accept_busy, req_valid && req_ready,
                    fsm_state != ppe_pkg::ST_IDLE, "controller idle after accept")
   // A finished divide always hands its result to the push step.
   `PPE_ASSERT_NEXT(a_div_to_push, fsm_state == ppe_pkg::ST_DIV && status.div_done,
                    fsm_state == ppe_pkg::ST_PUSH, "divide result not pushed")

endmodule
